// ===== rtl/crc32_forge_patch_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-32 forge patch unit
// Clocked, reset-qualified property wrappers.
// ----------------------------------------------------------------------------
`ifndef CRC32_FORGE_PATCH_UNIT_ASSERT_SVH
`define CRC32_FORGE_PATCH_UNIT_ASSERT_SVH

// pre in one cycle implies post in the next
`define CFP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cfp next-cycle check failed");

// cond holds at every edge
`define CFP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cfp invariant check failed");

`endif

// ===== rtl/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Types, constant tables and helpers for the CRC-32 forge patch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

  typedef logic [CRC_W-1:0]             crc_t;
  typedef logic [BYTE_W-1:0]            byte_t;
  typedef logic [255:0][CRC_W-1:0]      crc_tab_t;
  typedef logic [CRC_W-1:0][CRC_W-1:0]  walk_mat_t;

  function automatic crc_tab_t gen_tab();
    crc_tab_t t;
    crc_t     r;
    for (int i = 0; i < 256; i++) begin
      r = crc_t'(i);
      for (int b = 0; b < 8; b++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TAB = gen_tab();

  // top byte of the table entries is a permutation
  function automatic byte_t inv_top(byte_t top);
    byte_t idx;
    idx = '0;
    for (int i = 0; i < 256; i++) begin
      if (CRC_TAB[i][31:24] == top) begin
        idx = byte_t'(i);
      end
    end
    return idx;
  endfunction

  // four backward CRC steps
  function automatic crc_t walk4(crc_t w);
    byte_t idx;
    crc_t  v;
    v = w;
    for (int s = 0; s < 4; s++) begin
      idx = inv_top(v[31:24]);
      v   = ((v ^ CRC_TAB[idx]) << 8) | {24'h000000, idx};
    end
    return v;
  endfunction

  // backward walk is linear over GF(2): one column per input bit
  function automatic walk_mat_t gen_walk_mat();
    walk_mat_t m;
    for (int i = 0; i < CRC_W; i++) begin
      m[i] = walk4(crc_t'(1) << i);
    end
    return m;
  endfunction

  localparam walk_mat_t WALK_MAT   = gen_walk_mat();
  localparam crc_t      WALK_RESET = walk4(CRC_ONES);

  function automatic crc_t apply_walk(crc_t x);
    crc_t v;
    v = '0;
    for (int i = 0; i < CRC_W; i++) begin
      if (x[i]) begin
        v = v ^ WALK_MAT[i];
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cfp_if.sv =====
// ----------------------------------------------------------------------------
// cfp channel interfaces
// Valid/ready channels for message bytes, results and the target register.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_in_if;
  logic           valid;
  logic           ready;
  cfp_pkg::byte_t data_byte;
  logic           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfp_out_if;
  logic          valid;
  logic          ready;
  cfp_pkg::crc_t message_crc;
  cfp_pkg::crc_t patch_word;

  modport source (output valid, output message_crc, output patch_word, input ready);
  modport sink   (input valid, input message_crc, input patch_word, output ready);
endinterface

interface cfp_cfg_if;
  logic          valid;
  logic          ready;
  cfp_pkg::crc_t target_crc;

  modport source (output valid, output target_crc, input ready);
  modport sink   (input valid, input target_crc, output ready);
endinterface

`default_nettype wire

// ===== rtl/crc32_forge_patch_unit.sv =====
// ----------------------------------------------------------------------------
// crc32_forge_patch_unit
// Reflected CRC-32 over a byte stream; on the last byte returns the message
// CRC and a 4-byte append patch that forces the configured target CRC.
// ----------------------------------------------------------------------------
// A result request is raised in the cycle after its last byte is accepted.
// Throughput: 1 byte per cycle while the output is not stalled, set by the
//   byte-wide table update of the running CRC register, which feeds back on itself every cycle.
// Config writes are always accepted (ready is always high).
// Reset: running CRC all ones, target 0, result register empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc32_forge_patch_unit_assert.svh"

module crc32_forge_patch_unit (
  input  wire           clk,
  input  wire           rst_n,
  cfp_in_if.sink        in_if,
  cfp_out_if.source     out_if,
  cfp_cfg_if.sink       cfg_if
);

  cfp_pkg::crc_t crc_r;
  cfp_pkg::crc_t crc_nxt;
  cfp_pkg::crc_t walk_r;
  cfp_pkg::crc_t message_crc_r;
  cfp_pkg::crc_t patch_word_r;
  logic          out_valid_r;
  logic          in_fire;
  logic          out_fire;
  logic          cfg_fire;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_valid_r && out_if.ready;
  assign cfg_fire = cfg_if.valid;

  always_comb begin
    crc_nxt = (crc_r >> 8) ^ cfp_pkg::CRC_TAB[crc_r[7:0] ^ in_if.data_byte];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= cfp_pkg::CRC_ONES;
      walk_r      <= cfp_pkg::WALK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        walk_r <= cfp_pkg::apply_walk(~cfg_if.target_crc);
      end
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        if (in_if.last_byte) begin
          crc_r       <= cfp_pkg::CRC_ONES;
          out_valid_r <= 1'b1;
        end else begin
          crc_r <= crc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_if.last_byte) begin
      message_crc_r <= ~crc_nxt;
      patch_word_r  <= walk_r ^ crc_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.message_crc = message_crc_r;
  assign out_if.patch_word  = patch_word_r;

  `CFP_ASSERT_NEXT(a_last_restarts, clk, rst_n, in_fire && in_if.last_byte,
                   out_valid_r && (crc_r == cfp_pkg::CRC_ONES))
  `CFP_ASSERT_NEXT(a_no_invented_result, clk, rst_n,
                   !out_valid_r && !(in_fire && in_if.last_byte), !out_valid_r)
  `CFP_ASSERT_ALWAYS(a_ready_when_empty, clk, rst_n, out_valid_r || in_if.ready)

endmodule

`default_nettype wire
